// ===== sv/ptmap_pkg.sv =====
`timescale 1ns / 1ps
package ptmap_pkg;

    localparam int TABLE_PAGES_DEF = 64;
    localparam int IDX_W = 9;
    localparam int FRAME_W = 40;
    localparam int VPN_W = 36;
    localparam int ENTRY_W = 64;
    localparam int REM_BITS = 8;                    // dividend bits per cycle
    localparam int REM_STEPS = FRAME_W / REM_BITS;

    localparam logic MODE_MAP = 1'b0;
    localparam logic MODE_UNMAP = 1'b1;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_MAPPED = 3'd1;
    localparam logic [2:0] ST_UNMAPPED = 3'd2;
    localparam logic [2:0] ST_USER = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    typedef struct packed {
        logic                 mode;
        logic [VPN_W-1:0]     virt_page;
        logic [FRAME_W-1:0]   phys_frame;
        logic                 user_acc;
        logic                 writable;
        logic                 executable;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [FRAME_W-1:0]   freed_frame;
    } t_out_item;

endpackage

// ===== sv/four_level_page_table_mapper.sv =====
`timescale 1ns / 1ps
// Four-level page table mapper.
// Input channel (i_in_valid / o_in_stall, payload i_in): one map or unmap
// request per item. Output channel (o_out_valid / i_out_stall, payload o_out):
// one status item per request. Config channel (i_cfg_valid / o_cfg_ready):
// table_base_frame; the user must write it only while idle, the block does not enforce this.
// Requests are handled one at a time by a walker around one table memory
// (synchronous read). Per level a present entry costs a read, an evaluate
// step and a pointer remainder; at the leaf level the entry is evaluated and
// updated, then the result goes through S_DONE to the output register and
// the walker returns to idle, where it takes the next item.
// A level that needs a new table page spends 512 clearing writes plus one
// entry write in place of the remainder. Failures end the walk early at the
// level where they occur.
// After reset the root table is cleared, with o_in_stall high.
// The result sits in an output register; the next item can be accepted
// while it waits. If the receiver stalls with a result still waiting,
// the walker holds its next result until the register frees up.
module four_level_page_table_mapper
    import ptmap_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FRAME_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(TABLE_PAGES);
    localparam int AW = PW + IDX_W;
    localparam int NW = $clog2(TABLE_PAGES + 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_REMW  = 3'd4;
    localparam logic [2:0] S_WRENT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         r_state;
    logic [1:0]         r_lvl;
    logic [PW-1:0]      r_page;
    logic [PW-1:0]      r_np;
    logic [NW-1:0]      r_nfp;
    logic [IDX_W-1:0]   r_cnt;
    logic               r_boot;
    t_in_item           r_item;
    logic [2:0]         r_status;
    logic [FRAME_W-1:0] r_freed;
    logic [ENTRY_W-1:0] r_ent;
    logic [FRAME_W-1:0] r_base;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [IDX_W-1:0]   idx;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] rd_data;
    logic               rem_start;
    logic               rem_done;
    logic [PW-1:0]      rem_out;
    logic               e_p;
    logic               e_u;
    logic [FRAME_W-1:0] e_frame;
    logic [FRAME_W-1:0] new_frame;

    always_comb begin
        case (r_lvl)
            2'd0:    idx = r_item.virt_page[35:27];
            2'd1:    idx = r_item.virt_page[26:18];
            2'd2:    idx = r_item.virt_page[17:9];
            default: idx = r_item.virt_page[8:0];
        endcase
    end

    assign e_p       = rd_data[0];
    assign e_u       = rd_data[2];
    assign e_frame   = rd_data[51:12];
    assign new_frame = r_base + FRAME_W'(r_nfp);

    // memory write mux: page clear, fresh pointer, leaf update
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_page, idx};
        mem_wdata = r_ent;
        rem_start = 1'b0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_np, r_cnt};
                mem_wdata = '0;
            end
            S_WRENT: begin
                mem_we = 1'b1;
            end
            S_EVAL: begin
                if (r_lvl == 2'd3) begin
                    if (r_item.mode == MODE_MAP && !e_p) begin
                        mem_we    = 1'b1;
                        mem_wdata = {!r_item.executable, 11'b0, r_item.phys_frame, 9'b0,
                                     r_item.user_acc, r_item.writable, 1'b1};
                    end else if (r_item.mode == MODE_UNMAP && e_p) begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_data[ENTRY_W-1:1], 1'b0};
                    end
                end else if (e_p && !(r_item.mode == MODE_MAP && e_u != r_item.user_acc)) begin
                    rem_start = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_boot      <= 1'b1;
            r_np        <= '0;
            r_cnt       <= '0;
            r_nfp       <= NW'(1);
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            // S_DONE handles the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= r_boot ? S_IDLE : S_WRENT;
                        r_boot  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item   <= i_in;
                        r_lvl    <= 2'd0;
                        r_page   <= '0;
                        r_status <= ST_OK;
                        r_freed  <= '0;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_lvl == 2'd3) begin
                        if (r_item.mode == MODE_MAP) begin
                            if (e_p) r_status <= ST_MAPPED;
                        end else if (!e_p) begin
                            r_status <= ST_UNMAPPED;
                        end else begin
                            r_freed <= e_frame;
                        end
                        r_state <= S_DONE;
                    end else if (!e_p && r_item.mode == MODE_MAP) begin
                        if (r_nfp >= NW'(TABLE_PAGES)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_np    <= r_nfp[PW-1:0];
                            r_nfp   <= r_nfp + 1'b1;
                            r_cnt   <= '0;
                            r_ent   <= {12'b0, new_frame, 9'b0, r_item.user_acc, 2'b11};
                            r_state <= S_CLR;
                        end
                    end else if (!e_p) begin
                        r_status <= ST_UNMAPPED;
                        r_state  <= S_DONE;
                    end else if (r_item.mode == MODE_MAP && e_u != r_item.user_acc) begin
                        r_status <= ST_USER;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_REMW;
                    end
                end
                S_REMW: begin
                    if (rem_done) begin
                        r_page  <= rem_out;
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_WRENT: begin
                    r_page  <= r_np;
                    r_lvl   <= r_lvl + 1'b1;
                    r_state <= S_RD;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid       <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.freed_frame <= r_freed;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ptmap_store #(.TABLE_PAGES(TABLE_PAGES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr ({r_page, idx}),
        .o_rdata (rd_data)
    );

    ptmap_rem #(.TABLE_PAGES(TABLE_PAGES), .PW(PW)) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (e_frame - r_base),
        .o_done  (rem_done),
        .o_rem   (rem_out)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/ptmap_store.sv =====
`timescale 1ns / 1ps
module ptmap_store
    import ptmap_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF,
    parameter int AW = $clog2(TABLE_PAGES) + IDX_W
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    localparam int DEPTH = TABLE_PAGES * (1 << IDX_W);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ptmap_rem.sv =====
`timescale 1ns / 1ps
module ptmap_rem
    import ptmap_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF,
    parameter int PW = $clog2(TABLE_PAGES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [FRAME_W-1:0] i_value,
    output logic               o_done,
    output logic [PW-1:0]      o_rem
);

    // restoring remainder, REM_BITS dividend bits per cycle
    localparam int RW = PW + 1;
    localparam int CW = $clog2(REM_STEPS + 1);

    logic [FRAME_W-1:0] r_val;
    logic [RW-1:0]      r_rem;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [RW-1:0]      n_rem;

    always_comb begin
        n_rem = r_rem;
        for (int k = 0; k < REM_BITS; k++) begin
            n_rem = {n_rem[RW-2:0], r_val[FRAME_W-1-k]};
            if (n_rem >= RW'(TABLE_PAGES)) begin
                n_rem = n_rem - RW'(TABLE_PAGES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_val  <= i_value;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_val <= r_val << REM_BITS;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(REM_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[PW-1:0];

endmodule

// ===== sv/ptmap_checker.sv =====
`timescale 1ns / 1ps
module ptmap_checker
    import ptmap_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("result or ready right after reset");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status <= ST_FULL)
        else $error("bad status code");

    a_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.freed_frame == '0)
        else $error("freed frame on failed request");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken during walk");

endmodule

bind four_level_page_table_mapper ptmap_checker u_ptmap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== tb/tb_four_level_page_table_mapper.sv =====
`timescale 1ns / 1ps
module tb_four_level_page_table_mapper;
    import ptmap_pkg::*;

    localparam int NPAGES = TABLE_PAGES_DEF;
    localparam int ENTRIES = 512;
    localparam int POOL_N = 10;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 306;
    localparam int LONG_HOLD = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    localparam logic [63:0] PTE_P = 64'h1;
    localparam logic [63:0] PTE_W = 64'h2;
    localparam logic [63:0] PTE_U = 64'h4;
    localparam logic [63:0] PTE_XD = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PTE_ADDR = 64'h000F_FFFF_FFFF_F000;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_req_row;

    typedef struct {
        bit        typed;
        t_out_item want;
    } t_want;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [FRAME_W-1:0] i_cfg_data;

    four_level_page_table_mapper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the table memory; a missing key reads as zero
    logic [63:0]        pt_mem [int];
    int unsigned        alloc_next;
    logic [FRAME_W-1:0] root_frame;

    t_out_item status_q [$];
    t_want     typed_q [$];
    int        mismatches;
    longint    cycles;
    bit        quiet;
    bit        hold_req;

    logic [26:0] pool_prefix [POOL_N];
    logic        pool_user [POOL_N];
    t_req_row    rows [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] pt_rd(int unsigned page, logic [8:0] idx);
        int key;
        key = int'(page * ENTRIES + idx);
        return pt_mem.exists(key) ? pt_mem[key] : 64'h0;
    endfunction

    function automatic int unsigned child_page(logic [63:0] e);
        logic [FRAME_W-1:0] rel;
        rel = e[51:12] - root_frame;
        return int'(rel % NPAGES);
    endfunction

    // walk one request through the shadow table and update it
    function automatic t_out_item walk_request(t_in_item r);
        t_out_item   res;
        logic [8:0]  idx [4];
        int unsigned page;
        logic [63:0] e;
        res.status = ST_OK;
        res.freed_frame = '0;
        page = 0;
        for (int l = 0; l < 4; l++) idx[l] = r.virt_page[35 - 9*l -: 9];
        for (int l = 0; l < 3 && res.status == ST_OK; l++) begin
            e = pt_rd(page, idx[l]);
            if (!e[0]) begin
                if (r.mode == MODE_UNMAP) begin
                    res.status = ST_UNMAPPED;
                end else if (alloc_next >= NPAGES) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) pt_mem.delete(int'(alloc_next * ENTRIES + i));
                    e = ({24'h0, root_frame + FRAME_W'(alloc_next)} << 12) & PTE_ADDR;
                    e = e | PTE_P | PTE_W | (r.user_acc ? PTE_U : 64'h0);
                    alloc_next++;
                    pt_mem[int'(page * ENTRIES + idx[l])] = e;
                end
            end
            if (res.status == ST_OK && r.mode == MODE_MAP && e[2] != r.user_acc)
                res.status = ST_USER;
            if (res.status == ST_OK)
                page = child_page(e);
        end
        if (res.status == ST_OK) begin
            e = pt_rd(page, idx[3]);
            if (r.mode == MODE_MAP) begin
                if (e[0]) begin
                    res.status = ST_MAPPED;
                end else begin
                    e = (({24'h0, r.phys_frame} << 12) & PTE_ADDR) | PTE_P;
                    if (r.user_acc) e = e | PTE_U;
                    if (r.writable) e = e | PTE_W;
                    if (!r.executable) e = e | PTE_XD;
                    pt_mem[int'(page * ENTRIES + idx[3])] = e;
                end
            end else if (!e[0]) begin
                res.status = ST_UNMAPPED;
            end else begin
                e = e & ~PTE_P;
                pt_mem[int'(page * ENTRIES + idx[3])] = e;
                res.freed_frame = e[51:12];
            end
        end
        return res;
    endfunction

    // acceptance, prediction and checking, all sampled at the rising edge
    always @(posedge i_clk) begin
        t_want     w;
        t_out_item p;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) root_frame = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                p = walk_request(i_in);
                w = typed_q.pop_front();
                status_q.push_back(w.typed ? w.want : p);
            end
            if (o_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item %p", o_out);
                end else begin
                    p = status_q.pop_front();
                    if (o_out.status !== p.status || o_out.freed_frame !== p.freed_frame) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, freed exp %h got %h",
                                     p.status, o_out.status, p.freed_frame, o_out.freed_frame);
                    end
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input t_in_item r, input bit typed, input t_out_item want);
        t_want w;
        w.typed = typed;
        w.want = want;
        typed_q.push_back(w);
        i_in <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [FRAME_W-1:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // while table pages are still free, moving the base by anything but a
    // multiple of the table count would aim pointers at uncleared pages
    function automatic logic [FRAME_W-1:0] legal_base(logic [FRAME_W-1:0] v);
        return (alloc_next >= NPAGES) ? v : {v[FRAME_W-1:6], 6'h0};
    endfunction

    function automatic logic [FRAME_W-1:0] rnd40();
        return {8'($urandom_range(0, 255)), $urandom};
    endfunction

    function automatic t_req_row mk(logic mode, logic [VPN_W-1:0] vp, logic [FRAME_W-1:0] pf,
                                    logic u, logic w, logic x, bit typed,
                                    logic [2:0] st, logic [FRAME_W-1:0] fr);
        t_req_row r;
        r.req.mode = mode;
        r.req.virt_page = vp;
        r.req.phys_frame = pf;
        r.req.user_acc = u;
        r.req.writable = w;
        r.req.executable = x;
        r.typed = typed;
        r.want.status = st;
        r.want.freed_frame = fr;
        return r;
    endfunction

    function automatic t_in_item rand_req(bit noise);
        t_in_item r;
        int       k;
        r.mode = 1'($urandom_range(0, 1));
        r.phys_frame = rnd40();
        r.writable = 1'($urandom_range(0, 1));
        r.executable = 1'($urandom_range(0, 1));
        if (noise) begin
            r.virt_page = {4'($urandom_range(0, 15)), $urandom};
            r.user_acc = 1'($urandom_range(0, 1));
        end else begin
            k = $urandom_range(0, POOL_N - 1);
            r.virt_page[35:9] = pool_prefix[k];
            r.virt_page[8:0] = ($urandom_range(0, 7) == 0) ? 9'($urandom)
                                                             : 9'($urandom_range(0, 15));
            r.user_acc = ($urandom_range(0, 9) == 0) ? ~pool_user[k] : pool_user[k];
        end
        return r;
    endfunction

    initial begin
        t_out_item none;
        logic [FRAME_W-1:0] v;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        mismatches = 0;
        cycles = 0;
        alloc_next = 1;
        root_frame = '0;
        none = '0;
        for (int i = 0; i < POOL_N; i++) begin
            pool_prefix[i] = 27'($urandom);
            pool_user[i] = 1'($urandom_range(0, 1));
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_base(legal_base(rnd40()));

        rows.push_back(mk(MODE_UNMAP, 36'h0, 40'h0, 0, 0, 0, 1, ST_UNMAPPED, 40'h0));
        rows.push_back(mk(MODE_MAP, 36'h0, 40'h12345, 0, 1, 1, 1, ST_OK, 40'h0));
        rows.push_back(mk(MODE_MAP, 36'h0, 40'h777, 0, 1, 1, 1, ST_MAPPED, 40'h0));
        rows.push_back(mk(MODE_MAP, 36'h1, 40'h1, 1, 1, 1, 1, ST_USER, 40'h0));
        rows.push_back(mk(MODE_UNMAP, 36'h0, 40'h0, 0, 0, 0, 1, ST_OK, 40'h12345));
        rows.push_back(mk(MODE_UNMAP, 36'h0, 40'h0, 0, 0, 0, 1, ST_UNMAPPED, 40'h0));
        rows.push_back(mk(MODE_MAP, '1, '1, 1, 0, 0, 1, ST_OK, 40'h0));
        rows.push_back(mk(MODE_UNMAP, '1, 40'h0, 1, 1, 1, 1, ST_OK, '1));
        rows.push_back(mk(MODE_MAP, '1, 40'h0, 1, 1, 1, 1, ST_OK, 40'h0));
        // unmap ignores the user bit
        rows.push_back(mk(MODE_UNMAP, '1, '1, 0, 0, 0, 1, ST_OK, 40'h0));
        rows.push_back(mk(MODE_MAP, 36'h200, rnd40(), 0, 0, 1, 0, ST_OK, 40'h0));
        rows.push_back(mk(MODE_MAP, 36'h1FF, rnd40(), 0, 1, 0, 0, ST_OK, 40'h0));
        rows.push_back(mk(MODE_UNMAP, 36'h8_0000_0000, 40'h0, 0, 0, 0, 1, ST_UNMAPPED, 40'h0));
        rows.push_back(mk(MODE_UNMAP, 36'h200, 40'h0, 1, 0, 0, 0, ST_OK, 40'h0));
        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: v = 40'h0;
                2: v = legal_base(40'hFF_FFFF_FFFF);
                4: v = legal_base(40'hFF_FFFF_FFFF);
                default: v = legal_base(rnd40());
            endcase
            write_base(v);
            quiet = (ph == PHASES - 1);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // table pages run out once random regions are let in
                send_req(rand_req(ph > 0 && $urandom_range(0, 4) == 0), 1'b0, none);
                if (ph == 3 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
